// ----- sv/mpa_pkg.sv -----
// ---------------------------------------------------------------------------
// Modular pointwise ALU package
// Shared widths, command codes and the side-band record that rides the pipe.
// ---------------------------------------------------------------------------
package mpa_pkg;

	localparam int CW = 14;
	localparam int PW = 2 * CW;
	localparam int MUW = 2 * CW;
	localparam int MU_STEPS = MUW + 1;
	localparam int MU_CNT_W = $clog2(MU_STEPS);

	localparam logic [CW-1:0] MODULUS_RESET = CW'(12289);

	localparam logic [1:0] CMD_ADD = 2'd0;
	localparam logic [1:0] CMD_SUB = 2'd1;
	localparam logic [1:0] CMD_MUL = 2'd2;
	localparam logic [1:0] CMD_DIV = 2'd3;

	typedef struct packed {
		logic [1:0]    cmd;
		logic          low_mod;
		logic [CW-1:0] ar;
		logic [CW-1:0] br;
		logic [CW-1:0] acc;
	} sb_t;

endpackage

// ----- sv/mpa_modmul.sv -----
// ---------------------------------------------------------------------------
// Pipelined modular multiplier
// Four stages: product, Barrett estimate, quotient back-multiply and subtract,
// final correction. A side-band record and a valid bit travel alongside.
// ---------------------------------------------------------------------------
module mpa_modmul (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      in_valid,
	input  mpa_pkg::sb_t              in_sb,
	input  logic [mpa_pkg::CW-1:0]    x,
	input  logic [mpa_pkg::CW-1:0]    y,
	input  logic [mpa_pkg::CW-1:0]    m,
	input  logic [mpa_pkg::MUW-1:0]   mu,
	output logic                      out_valid,
	output mpa_pkg::sb_t              out_sb,
	output logic [mpa_pkg::CW-1:0]    prod
);

	logic                              valid_s1, valid_s2, valid_s3, valid_s4;
	mpa_pkg::sb_t                      sb_s1, sb_s2, sb_s3, sb_s4;
	logic [mpa_pkg::PW-1:0]            p_s1, p_s2, q_s2;
	logic [mpa_pkg::CW:0]              r_s3;
	logic [mpa_pkg::CW-1:0]            prod_s4;
	logic [2*mpa_pkg::PW-1:0]          est;
	logic [mpa_pkg::PW+mpa_pkg::CW-1:0] qm;
	logic [mpa_pkg::PW-1:0]            diff;
	logic [mpa_pkg::CW:0]              r_sub;

	assign est   = (2*mpa_pkg::PW)'(p_s1) * (2*mpa_pkg::PW)'(mu);
	assign qm    = (mpa_pkg::PW+mpa_pkg::CW)'(q_s2) * (mpa_pkg::PW+mpa_pkg::CW)'(m);
	assign diff  = p_s2 - qm[mpa_pkg::PW-1:0];
	assign r_sub = r_s3 - {1'b0, m};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sb_s1   <= in_sb;
			p_s1    <= mpa_pkg::PW'(x) * mpa_pkg::PW'(y);
			sb_s2   <= sb_s1;
			p_s2    <= p_s1;
			q_s2    <= est[2*mpa_pkg::PW-1:mpa_pkg::PW];
			sb_s3   <= sb_s2;
			r_s3    <= diff[mpa_pkg::CW:0];
			sb_s4   <= sb_s3;
			prod_s4 <= (r_s3 >= {1'b0, m}) ? r_sub[mpa_pkg::CW-1:0]
			                               : r_s3[mpa_pkg::CW-1:0];
		end
	end

	assign out_valid = valid_s4;
	assign out_sb    = sb_s4;
	assign prod      = prod_s4;

endmodule

// ----- sv/modular_pointwise_alu_top.sv -----
// ---------------------------------------------------------------------------
// Modular pointwise ALU
// Add, subtract, multiply and divide of coefficient pairs modulo a prime.
// ---------------------------------------------------------------------------
// One request enters per cycle while in_stall is low; the pipeline depth is
// set by the Fermat inverse, one square-and-multiply step of four stages per
// exponent bit, plus input reduction and the final multiply. Every command
// takes the same path, so order is kept. After reset and after each write of
// the modulus, a serial divider computes the Barrett reciprocal and in_stall
// stays high until it is done.
module modular_pointwise_alu_top (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_wr_en,
	input  logic [mpa_pkg::CW-1:0] cfg_wr_data,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [1:0]             command,
	input  logic [mpa_pkg::CW-1:0] operand_a,
	input  logic [mpa_pkg::CW-1:0] operand_b,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [mpa_pkg::CW-1:0] value,
	output logic                   div_error
);

	localparam int CW = mpa_pkg::CW;

	logic [CW-1:0]                   modulus_q;
	logic                            busy_q;
	logic [mpa_pkg::MU_CNT_W-1:0]    cnt_q;
	logic [CW-1:0]                   rem_q;
	logic [mpa_pkg::MUW-1:0]         quo_q;
	logic [CW:0]                     trial;
	logic [CW:0]                     trial_sub;
	logic                            qbit;

	logic                            en;
	logic [CW-1:0]                   expo;
	logic                            low_mod;
	mpa_pkg::sb_t                    entry_sb;
	mpa_pkg::sb_t                    red_sb;
	logic                            red_valid;
	logic [CW-1:0]                   ra, rb;

	mpa_pkg::sb_t                    step_sb [0:CW];
	logic                            step_v  [0:CW];
	logic [CW-1:0]                   bb      [0:CW];

	mpa_pkg::sb_t                    fin_sb;
	logic                            fin_valid;
	logic [CW-1:0]                   fin_prod;
	logic [CW-1:0]                   fin_y;

	logic                            res_valid_so;
	logic [CW-1:0]                   res_value_so;
	logic                            res_err_so;
	logic [CW:0]                     sum;
	logic [CW:0]                     sum_sub;
	logic [CW:0]                     dif_wrap;
	logic [CW-1:0]                   nxt_value;
	logic                            nxt_err;

	// reciprocal: floor(2^MUW / modulus), one quotient bit per cycle
	assign trial     = {rem_q, (cnt_q == '0)};
	assign trial_sub = trial - {1'b0, modulus_q};
	assign qbit      = (trial >= {1'b0, modulus_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= mpa_pkg::MODULUS_RESET;
			busy_q    <= 1'b1;
			cnt_q     <= '0;
			rem_q     <= '0;
			quo_q     <= '0;
		end else if (cfg_wr_en) begin
			modulus_q <= cfg_wr_data;
			busy_q    <= 1'b1;
			cnt_q     <= '0;
			rem_q     <= '0;
			quo_q     <= '0;
		end else if (busy_q) begin
			rem_q <= qbit ? trial_sub[CW-1:0] : trial[CW-1:0];
			quo_q <= {quo_q[mpa_pkg::MUW-2:0], qbit};
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == mpa_pkg::MU_CNT_W'(mpa_pkg::MU_STEPS - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	assign en       = !res_valid_so || !out_stall;
	assign in_stall = !en || busy_q;
	assign expo     = modulus_q - CW'(2);
	assign low_mod  = (modulus_q <= CW'(1));

	always_comb begin
		entry_sb         = '0;
		entry_sb.cmd     = command;
		entry_sb.low_mod = low_mod;
	end

	mpa_modmul u_red_a (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(in_valid && !busy_q), .in_sb(entry_sb),
		.x(operand_a), .y(CW'(1)), .m(modulus_q), .mu(quo_q),
		.out_valid(red_valid), .out_sb(red_sb), .prod(ra)
	);

	mpa_modmul u_red_b (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(in_valid && !busy_q), .in_sb(entry_sb),
		.x(operand_b), .y(CW'(1)), .m(modulus_q), .mu(quo_q),
		.out_valid(), .out_sb(), .prod(rb)
	);

	always_comb begin
		step_sb[0]     = red_sb;
		step_sb[0].ar  = ra;
		step_sb[0].br  = rb;
		step_sb[0].acc = CW'(1);
	end
	assign step_v[0] = red_valid;
	assign bb[0]     = rb;

	for (genvar k = 0; k < CW; k++) begin : g_step
		mpa_pkg::sb_t  p_sb;
		logic          p_valid;
		logic [CW-1:0] p_prod;

		mpa_modmul u_mul (
			.clk(clk), .arst_n(arst_n), .en(en),
			.in_valid(step_v[k]), .in_sb(step_sb[k]),
			.x(step_sb[k].acc), .y(bb[k]), .m(modulus_q), .mu(quo_q),
			.out_valid(p_valid), .out_sb(p_sb), .prod(p_prod)
		);

		mpa_modmul u_sqr (
			.clk(clk), .arst_n(arst_n), .en(en),
			.in_valid(step_v[k]), .in_sb(step_sb[k]),
			.x(bb[k]), .y(bb[k]), .m(modulus_q), .mu(quo_q),
			.out_valid(), .out_sb(), .prod(bb[k+1])
		);

		always_comb begin
			step_sb[k+1] = p_sb;
			if (expo[k]) begin
				step_sb[k+1].acc = p_prod;
			end
		end
		assign step_v[k+1] = p_valid;
	end

	assign fin_y = (step_sb[CW].cmd == mpa_pkg::CMD_DIV) ? step_sb[CW].acc : step_sb[CW].br;

	mpa_modmul u_final (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(step_v[CW]), .in_sb(step_sb[CW]),
		.x(step_sb[CW].ar), .y(fin_y), .m(modulus_q), .mu(quo_q),
		.out_valid(fin_valid), .out_sb(fin_sb), .prod(fin_prod)
	);

	assign sum      = {1'b0, fin_sb.ar} + {1'b0, fin_sb.br};
	assign sum_sub  = sum - {1'b0, modulus_q};
	assign dif_wrap = {1'b0, fin_sb.ar} + {1'b0, modulus_q} - {1'b0, fin_sb.br};

	always_comb begin
		nxt_value = '0;
		nxt_err   = 1'b0;
		if (fin_sb.low_mod) begin
			nxt_err = (fin_sb.cmd == mpa_pkg::CMD_DIV);
		end else begin
			unique case (fin_sb.cmd)
				mpa_pkg::CMD_ADD: begin
					nxt_value = (sum >= {1'b0, modulus_q}) ? sum_sub[CW-1:0] : sum[CW-1:0];
				end
				mpa_pkg::CMD_SUB: begin
					nxt_value = (fin_sb.ar >= fin_sb.br) ? (fin_sb.ar - fin_sb.br)
					                                     : dif_wrap[CW-1:0];
				end
				mpa_pkg::CMD_MUL: begin
					nxt_value = fin_prod;
				end
				default: begin
					nxt_err   = (fin_sb.br == '0);
					nxt_value = nxt_err ? '0 : fin_prod;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_so <= 1'b0;
		end else if (en) begin
			res_valid_so <= fin_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_value_so <= nxt_value;
			res_err_so   <= nxt_err;
		end
	end

	assign out_valid = res_valid_so;
	assign value     = res_value_so;
	assign div_error = res_err_so;

	a_busy_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> in_stall)
		else $error("input taken while reciprocal not ready");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && div_error) |-> (value == '0))
		else $error("divide error with nonzero value");

	a_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !busy_q && modulus_q > CW'(1)) |-> (value < modulus_q))
		else $error("result not reduced");

endmodule
